// ----- sv/ptr_pkg.sv -----
// ----------------------------------------------------------------------------
// ptr_pkg
// shared types and constants for the page translation and replacement block
// ----------------------------------------------------------------------------
package ptr_pkg;

  localparam int unsigned NumFramesDefault = 64;
  localparam int unsigned AddrBitsDefault  = 32;
  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned PaBits           = 26;
  localparam int unsigned CntBits          = 32;
  localparam int unsigned CfgIdxBits       = 2;
  localparam int unsigned CfgDataBits      = 7;

  localparam logic [CfgIdxBits-1:0] CfgOffsetBits  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgFramesInUse = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgPolicy      = 2'd2;

  localparam logic [1:0] PolFifo  = 2'd0;
  localparam logic [1:0] PolClock = 2'd1;
  localparam logic [1:0] PolLfu   = 2'd2;

  typedef struct packed {
    logic [31:0] logical_address;
    logic        write_access;
  } in_item_t;

  typedef struct packed {
    logic [PaBits-1:0]  physical_address;
    logic               page_fault;
    logic               swapped_out;
    logic [CntBits-1:0] fault_total;
    logic [CntBits-1:0] swap_in_total;
    logic [CntBits-1:0] swap_out_total;
    logic [CntBits-1:0] reference_total;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item, reset scan index to 0
    logic scan_next; // advance scan index
    logic scan_hand; // load scan index from hand (0 if past the last frame), frame 0 for lfu
    logic clr_ref;   // clear clock bit at scan index, advance with wrap
    logic mark_hit;  // track the hit frame (search)
    logic mark_free; // track the free frame
    logic mark_lfu;  // compare use count for lfu minimum
    logic vict_scan; // victim is the scan index
    logic vict_lfu;  // victim is lfu best
    logic commit;    // update frame state and counters, write result
  } ptr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // scan index is last frame
    logic hit;       // entry at scan index valid and holds page
    logic free;      // entry at scan index invalid
    logic refbit;    // clock bit at scan index
    logic [1:0] pol;
  } ptr_sts_t;

endpackage

// ----- sv/page_translate_replace.sv -----
// ----------------------------------------------------------------------------
// page_translate_replace
// inverted page table translation with fifo, clock or lfu replacement
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in       input      in_valid / in_stall, payload in_item
// out      output     out_valid / out_stall, payload out_item
// cfg      input      cfg_we, cfg_idx, cfg_data
//
// one transaction at a time; the search reads one frame at a time through
// the registered page ram, with a wait state after each index change; a hit
// ends it, a miss takes a free frame if one was seen, else a fifo or clock
// victim is scanned from the hand, lfu adds a one-frame-per-cycle pass over
// all frames, and a clock sweep clears each set clock bit until a clear one
// reset clears the valid, dirty and clock bits, hand and counters
// a result waits in its register under out_stall; the next transaction is
// refused until it is taken
module page_translate_replace import ptr_pkg::*; #(
  parameter int unsigned NumFrames = NumFramesDefault,
  parameter int unsigned AddrBits  = AddrBitsDefault,
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data
);
  ptr_cmd_t cmd;
  ptr_sts_t sts;

  ptr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  ptr_datapath #(.NumFrames(NumFrames), .AddrBits(AddrBits), .CountBits(CountBits))
  u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .in_item, .cmd, .sts, .out_item
  );
endmodule

// ----- sv/ptr_ram.sv -----
// ----------------------------------------------------------------------------
// ptr_ram
// generic simple dual port ram (separate write and read address) with registered read
// ----------------------------------------------------------------------------
module ptr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                            wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                            rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ptr_datapath.sv -----
// ----------------------------------------------------------------------------
// ptr_datapath
// frame tables, scan index, victim tracking, counters and result register
// ----------------------------------------------------------------------------
module ptr_datapath import ptr_pkg::*; #(
  parameter int unsigned NumFrames = NumFramesDefault,
  parameter int unsigned AddrBits  = AddrBitsDefault,
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data,
  input  in_item_t               in_item,
  input  ptr_cmd_t               cmd,
  output ptr_sts_t               sts,
  output out_item_t              out_item
);
  localparam int unsigned IdxBits = (NumFrames > 1) ? $clog2(NumFrames) : 1;
  localparam logic [CountBits-1:0] UseMax = '1;

  logic [4:0] offset_bits;
  logic [6:0] frames_in_use;
  logic [1:0] policy;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits   <= 5'd12;
      frames_in_use <= 7'd64;
      policy        <= PolFifo;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgOffsetBits:  offset_bits   <= cfg_data[4:0];
        CfgFramesInUse: frames_in_use <= cfg_data;
        CfgPolicy:      policy        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective frame count minus one
  logic [IdxBits-1:0] last_idx;
  always_comb begin
    if (frames_in_use == 7'd0) begin
      last_idx = '0;
    end else if (32'(frames_in_use) > NumFrames) begin
      last_idx = IdxBits'(NumFrames - 1);
    end else begin
      last_idx = IdxBits'(frames_in_use - 7'd1);
    end
  end

  logic [AddrBits-1:0] page;
  logic [31:0]         offset;
  logic                wr;
  logic [4:0]          ob;
  logic [IdxBits-1:0]  idx, hand;
  logic [IdxBits-1:0]  hit_idx, free_idx, best_idx, frame;
  logic                hit_f, free_f, best_f;
  logic [CountBits-1:0] best_cnt;

  logic [NumFrames-1:0] valid, dirty, refb;

  logic [AddrBits-1:0]  page_rd;
  logic [CountBits-1:0] use_rd;
  logic [CountBits-1:0] use_wdata;
  logic [IdxBits-1:0]   idx_next;
  logic                 in_range;

  // read address follows next scan index so data lines up
  always_comb begin
    idx_next = idx;
    if (cmd.load) begin
      idx_next = '0;
    end else if (cmd.scan_hand) begin
      if (policy == PolLfu) idx_next = '0;
      else idx_next = (hand <= last_idx) ? hand : '0;
    end else if (cmd.scan_next || cmd.clr_ref) begin
      idx_next = (idx == last_idx) ? '0 : idx + 1'b1;
    end
  end

  logic [AddrBits-1:0] addr_m;
  assign addr_m = AddrBits'(in_item.logical_address);

  ptr_ram #(.Width(AddrBits), .Depth(NumFrames)) u_page_ram (
    .clk   (clk),
    .we    (cmd.commit && !hit_f),
    .waddr (frame),
    .wdata (page),
    .raddr (idx_next),
    .rdata (page_rd)
  );

  // use counts are only read for valid frames, which were loaded first
  assign use_wdata = !hit_f ? CountBits'(1) :
                     ((use_rd == UseMax) ? use_rd : use_rd + 1'b1);

  ptr_ram #(.Width(CountBits), .Depth(NumFrames)) u_use_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (frame),
    .wdata (use_wdata),
    .raddr (idx_next),
    .rdata (use_rd)
  );

  assign in_range   = 1'b1;
  assign sts.last   = (idx == last_idx);
  assign sts.hit    = valid[idx] && (page_rd == page) && in_range;
  assign sts.free   = !valid[idx];
  assign sts.refbit = refb[idx];
  assign sts.pol    = policy;

  always_comb begin
    if (hit_f) frame = hit_idx;
    else if (free_f) frame = free_idx;
    else if (cmd.vict_lfu || best_f) frame = best_idx;
    else frame = idx;
  end

  logic [CntBits-1:0] fault_c, swin_c, swout_c, acc_c;
  logic               vdirty;
  assign vdirty = !hit_f && !free_f && dirty[frame];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      dirty   <= '0;
      refb    <= '0;
      hand    <= '0;
      idx     <= '0;
      fault_c <= '0;
      swin_c  <= '0;
      swout_c <= '0;
      acc_c   <= '0;
      hit_f   <= 1'b0;
      free_f  <= 1'b0;
      best_f  <= 1'b0;
    end else begin
      idx <= idx_next;
      if (cmd.load) begin
        wr     <= in_item.write_access;
        ob     <= offset_bits;
        page   <= addr_m >> offset_bits;
        offset <= 32'(addr_m) & ((32'd1 << offset_bits) - 32'd1);
        hit_f  <= 1'b0;
        free_f <= 1'b0;
        best_f <= 1'b0;
      end
      if (cmd.mark_hit && sts.hit && !hit_f) begin
        hit_f   <= 1'b1;
        hit_idx <= idx;
      end
      if (cmd.mark_free && sts.free && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= idx;
      end
      if (cmd.mark_lfu) begin
        if (idx == '0 || use_rd < best_cnt) begin
          best_idx <= idx;
          best_cnt <= use_rd;
        end
      end
      if (cmd.vict_lfu) best_f <= 1'b1;
      if (cmd.clr_ref) refb[idx] <= 1'b0;
      if (cmd.vict_scan) begin
        best_f   <= 1'b1;
        best_idx <= idx;
        hand     <= (idx == last_idx) ? '0 : idx + 1'b1;
      end
      if (cmd.commit) begin
        refb[frame] <= 1'b1;
        if (hit_f) begin
          if (wr) dirty[frame] <= 1'b1;
        end else begin
          valid[frame]   <= 1'b1;
          dirty[frame]   <= wr;
          if (fault_c != '1) fault_c <= fault_c + 1'b1;
          if (swin_c != '1) swin_c <= swin_c + 1'b1;
          if (vdirty && swout_c != '1) swout_c <= swout_c + 1'b1;
        end
        if (acc_c != '1) acc_c <= acc_c + 1'b1;
        out_item.physical_address <= PaBits'((64'(frame) << ob) | 64'(offset));
        out_item.page_fault      <= !hit_f;
        out_item.swapped_out     <= vdirty;
        out_item.fault_total     <= (hit_f || fault_c == '1) ? fault_c : fault_c + 1'b1;
        out_item.swap_in_total   <= (hit_f || swin_c == '1) ? swin_c : swin_c + 1'b1;
        out_item.swap_out_total  <= (!vdirty || swout_c == '1) ? swout_c : swout_c + 1'b1;
        out_item.reference_total <= (acc_c == '1) ? acc_c : acc_c + 1'b1;
      end
    end
  end
endmodule

// ----- sv/ptr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptr_ctrl
// sequencer for search, free scan, victim choice and commit
// ----------------------------------------------------------------------------
module ptr_ctrl import ptr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ptr_sts_t sts,
  output ptr_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_FREE, S_VICT, S_LFU, S_CLOCK, S_COMMIT
  } state_t;
  state_t state;
  logic   dly; // wait state for the ram read after an index change
  logic   found;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load = in_valid && !in_stall;
      S_SEARCH: if (!dly) begin
        cmd.mark_hit  = 1'b1;
        cmd.mark_free = 1'b1;
        cmd.scan_next = !sts.hit && !sts.last;
      end
      S_FREE:   ;
      S_VICT:   cmd.scan_hand = 1'b1;
      S_LFU: begin
        cmd.mark_lfu  = 1'b1;
        cmd.scan_next = !sts.last;
        cmd.vict_lfu  = sts.last;
      end
      S_CLOCK: if (!dly) begin
        cmd.clr_ref   = (sts.pol == PolClock) && sts.refbit;
        cmd.vict_scan = !((sts.pol == PolClock) && sts.refbit);
      end
      S_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dly       <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      dly <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.load) begin
          state <= S_SEARCH;
          dly   <= 1'b1;
          found <= 1'b0;
        end
        S_SEARCH: if (!dly) begin
          if (sts.free) found <= 1'b1;
          if (sts.hit) state <= S_COMMIT;
          else if (sts.last) state <= S_FREE;
          else dly <= 1'b1;
        end
        S_FREE: state <= found ? S_COMMIT : S_VICT;
        S_VICT: begin
          state <= (sts.pol == PolLfu) ? S_LFU : S_CLOCK;
          dly   <= (sts.pol != PolLfu);
        end
        S_LFU: if (sts.last) state <= S_COMMIT;
        S_CLOCK: if (!dly) begin
          if (cmd.vict_scan) state <= S_COMMIT;
          else dly <= 1'b1;
        end
        S_COMMIT: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/ptr_checker.sv -----
// ----------------------------------------------------------------------------
// ptr_checker
// port level checks for page_translate_replace
// ----------------------------------------------------------------------------
module ptr_checker import ptr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("result dropped");
  // accepted transaction raises no result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("early result");
  // a rising out_valid that had out_valid set before it shows a nonzero reference total
  a_mono: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && $past(out_valid, 2) |->
    out_item.reference_total != '0) else $error("counter wrapped");
  // swap-out only comes with a fault
  a_swap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.swapped_out |-> out_item.page_fault) else $error("swap on hit");
endmodule

bind page_translate_replace ptr_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);
